// File: rtl/imhq_pkg.sv
// Shared types and codes for the indexed min-heap queue.
`timescale 1ns / 1ps
package imhq_pkg;
   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_DELMIN   = 2'd1;
   localparam logic [1:0] CMD_DECREASE = 2'd2;
   localparam logic [1:0] CMD_NONE     = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_RAISED  = 3'd4;
   localparam logic [2:0] ST_PRESENT = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [9:0]  vertex;
   } req_type;

   typedef struct packed {
      logic [9:0]  min_vertex;
      logic [2:0]  status;
      logic [10:0] entry_count;
   } rsp_type;
endpackage

// File: rtl/imhq_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps
interface imhq_req_if import imhq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/imhq_rsp_if.sv
// Response channel interface.
`timescale 1ns / 1ps
interface imhq_rsp_if import imhq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/imhq_ram.sv
// Single-port RAM with registered read data.
`timescale 1ns / 1ps
module imhq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// File: rtl/indexed_min_heap_queue.sv
// Top level: indexed binary min-heap with insert, delete-min and decrease-key.
// Usage:
//  - req carries cmd, key, vertex; rsp returns min_vertex, status, entry_count.
//  - One request is processed at a time; req_ready is low while busy.
//  - Response time depends on the command and on how many levels an entry
//    moves: an answer that moves nothing is quickest; insert and decrease-key
//    add time per level moved up, delete-min per level moved down. Each entry
//    compared costs a read of the single-port heap RAM, whose read data is
//    registered.
//  - req_ready rises again in the cycle after the response transfer.
//  - After reset a clearing pass writes zero to every position table entry,
//    during which no request is taken.
//  - The result waits in an output register while rsp_ready is low; the next
//    request is taken only once it has been transferred.
//  - Out-of-range, duplicate, full, empty and raised-key cases answer with
//    status codes and leave the heap unchanged.
`timescale 1ns / 1ps
module indexed_min_heap_queue import imhq_pkg::*; #(
   parameter int CAPACITY     = 1024,
   parameter int NUM_VERTICES = 1024,
   parameter int KEY_BITS     = 32
) (
   input logic clock,
   input logic reset,
   imhq_req_if.sink   req,
   imhq_rsp_if.source rsp
);
   localparam int AW = $clog2(CAPACITY + 1);
   localparam int PW = AW;
   localparam int TW = $clog2(NUM_VERTICES);
   localparam int EW = KEY_BITS + 10;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2,
      S_LOOKW = 4'd3, S_DISP = 4'd4, S_RDA = 4'd5, S_RDAW = 4'd6, S_RDB = 4'd7,
      S_RDBW = 4'd8, S_STEP = 4'd9, S_WPOS = 4'd10, S_FIN = 4'd11,
      S_OUT = 4'd12, S_RDLAST = 4'd13, S_RDROOT = 4'd14;

   logic [3:0] state_ff, state_in;
   req_type    req_ff, req_in;
   rsp_type    rsp_ff, rsp_in;
   logic [AW-1:0] occ_ff, occ_in, p_ff, p_in, c_ff, c_in;
   logic [KEY_BITS-1:0] k_ff, k_in, ka_ff, ka_in;
   logic [9:0] v_ff, v_in, va_ff, va_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic up_ff, up_in;

   // heap RAM (key,vertex), position RAM
   logic          hwe;
   logic [AW-1:0] haddr;
   logic [EW-1:0] hwd, hrd;
   logic          twe;
   logic [TW-1:0] taddr;
   logic [PW-1:0] twd, trd;

   imhq_ram #(.DEPTH(1 << AW), .WIDTH(EW)) u_heap (
      .clock(clock), .we(hwe), .addr(haddr), .wdata(hwd), .rdata(hrd));
   imhq_ram #(.DEPTH(1 << TW), .WIDTH(PW)) u_pos (
      .clock(clock), .we(twe), .addr(taddr), .wdata(twd), .rdata(trd));

   logic [KEY_BITS-1:0] rk;
   logic [9:0] rv;
   logic [KEY_BITS-1:0] nkey;
   logic vok;
   assign rk = hrd[EW-1:10];
   assign rv = hrd[9:0];
   assign nkey = KEY_BITS'(req_ff.key);
   assign vok = ({22'd0, req_ff.vertex} < 32'(NUM_VERTICES));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff; occ_in = occ_ff;
      p_in = p_ff; c_in = c_ff; k_in = k_ff; ka_in = ka_ff; v_in = v_ff;
      va_in = va_ff; clr_in = clr_ff; up_in = up_ff;
      hwe = 1'b0; haddr = p_ff; hwd = {k_ff, v_ff};
      twe = 1'b0; taddr = TW'(req_ff.vertex); twd = '0;
      case (state_ff)
         S_CLEAR: begin
            twe = 1'b1; taddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == TW'(NUM_VERTICES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               req_in = req.data; state_in = S_LOOK; c_in = '0;
            end
         end
         S_LOOK: state_in = S_LOOKW;
         S_LOOKW: begin
            // trd holds position of vertex; read heap at it for decrease
            p_in = trd; haddr = trd; state_in = S_DISP;
         end
         S_DISP: begin
            rsp_in.min_vertex = '0; rsp_in.status = ST_OK;
            state_in = S_FIN;
            k_in = nkey; v_in = req_ff.vertex;
            case (req_ff.cmd)
               CMD_INSERT: begin
                  if (!vok) rsp_in.status = ST_ABSENT;
                  else if (p_ff != '0) rsp_in.status = ST_PRESENT;
                  else if (32'(occ_ff) >= 32'(CAPACITY)) rsp_in.status = ST_FULL;
                  else begin
                     occ_in = occ_ff + 1'b1; p_in = occ_ff + 1'b1;
                     up_in = 1'b1; state_in = S_RDA;
                  end
               end
               CMD_DELMIN: begin
                  if (occ_ff == '0) rsp_in.status = ST_EMPTY;
                  else begin
                     haddr = occ_ff; state_in = S_RDLAST;
                  end
               end
               CMD_DECREASE: begin
                  if (!vok || p_ff == '0 || p_ff > occ_ff)
                     rsp_in.status = ST_ABSENT;
                  else if (nkey > rk) rsp_in.status = ST_RAISED;
                  else begin
                     up_in = 1'b1; state_in = S_RDA;
                  end
               end
               default: ;
            endcase
         end
         S_RDLAST: begin
            haddr = occ_ff; state_in = S_RDROOT;
         end
         S_RDROOT: begin
            k_in = rk; v_in = rv; haddr = AW'(1); state_in = S_RDAW;
            up_in = 1'b0; p_in = AW'(1);
         end
         S_RDAW: begin
            // root read back: output its vertex, clear its position
            if (!up_ff && state_ff == S_RDAW) begin
               rsp_in.min_vertex = rv;
               twe = 1'b1; taddr = TW'(rv); twd = '0;
               occ_in = occ_ff - 1'b1;
               if (occ_ff == AW'(1)) state_in = S_FIN;
               else state_in = S_STEP;
               c_in = '0;
            end
         end
         S_RDA: begin
            // up: read parent of p
            if (p_ff <= AW'(1)) state_in = S_WPOS;
            else begin
               haddr = p_ff >> 1; state_in = S_RDB;
            end
         end
         S_RDB: begin
            if (up_ff) haddr = p_ff >> 1;
            else haddr = {p_ff[AW-2:0], 1'b0};
            state_in = S_RDBW;
         end
         S_RDBW: begin
            if (up_ff) begin
               if (rk > k_ff) begin
                  hwe = 1'b1; haddr = p_ff; hwd = hrd;
                  twe = 1'b1; taddr = TW'(rv); twd = p_ff;
                  p_in = p_ff >> 1; state_in = S_RDA;
               end else state_in = S_WPOS;
            end else begin
               // down: c_ff is chosen child, ka/va its entry after compare
               if (c_ff == '0) begin
                  // first child read
                  ka_in = rk; va_in = rv; c_in = {p_ff[AW-2:0], 1'b0};
                  if ({p_ff[AW-2:0], 1'b0} != occ_ff) begin
                     haddr = {p_ff[AW-2:0], 1'b1}; state_in = S_LOOK;
                     up_in = 1'b0;
                  end else state_in = S_STEP;
                  p_in = p_ff;
               end
            end
         end
         S_STEP: begin
            // down: start a level or finish
            if (c_ff == '0) begin
               if (32'(p_ff) * 2 > 32'(occ_ff)) state_in = S_WPOS;
               else begin
                  haddr = {p_ff[AW-2:0], 1'b0}; state_in = S_RDB;
                  p_in = p_ff;
               end
            end else begin
               if (k_ff > ka_ff) begin
                  hwe = 1'b1; haddr = p_ff; hwd = {ka_ff, va_ff};
                  twe = 1'b1; taddr = TW'(va_ff); twd = p_ff;
                  p_in = c_ff; c_in = '0;
               end else state_in = S_WPOS;
            end
         end
         S_WPOS: begin
            hwe = 1'b1; haddr = p_ff; hwd = {k_ff, v_ff};
            twe = 1'b1; taddr = TW'(v_ff); twd = p_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            rsp_in.entry_count = 11'(occ_ff); state_in = S_OUT;
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // second child read in down path reuses S_LOOK code with up_ff low
      if (state_ff == S_LOOK && !up_ff && req_ff.cmd == CMD_DELMIN &&
          c_ff != '0) begin
         haddr = c_ff + 1'b1; state_in = S_LOOKW;
      end
      if (state_ff == S_LOOKW && !up_ff && req_ff.cmd == CMD_DELMIN &&
          c_ff != '0) begin
         haddr = p_ff; p_in = p_ff;
         if (rk < ka_ff) begin
            ka_in = rk; va_in = rv; c_in = c_ff + 1'b1;
         end
         state_in = S_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; occ_ff <= '0; clr_ff <= '0; up_ff <= 1'b0;
      end else begin
         state_ff <= state_in; occ_ff <= occ_in; clr_ff <= clr_in;
         up_ff <= up_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; p_ff <= p_in; c_ff <= c_in;
      k_ff <= k_in; ka_ff <= ka_in; v_ff <= v_in; va_ff <= va_in;
   end
endmodule
